>>> rtl/core/ketrq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ketrq_pkg;

	// Action codes carried by the input item
	localparam logic [2:0] ACT_TICK    = 3'd0;
	localparam logic [2:0] ACT_HOLD    = 3'd1;
	localparam logic [2:0] ACT_REPEAT  = 3'd2;
	localparam logic [2:0] ACT_PRESS   = 3'd3;
	localparam logic [2:0] ACT_RELEASE = 3'd4;
	localparam logic [2:0] ACT_TOGGLE  = 3'd5;

	localparam int TimeWidth = 32;

	// One per-key record as held in the key memory
	typedef struct packed {
		logic                 down_mark;
		logic                 up_mark;
		logic                 toggle_mark;
		logic [TimeWidth-1:0] last_fire_time;
	} entry_t;

	localparam int EntryWidth = $bits(entry_t);

	// Query decoded for the update logic
	typedef struct packed {
		logic [2:0]           action;
		logic                 key_ok;
		logic                 down;
		logic [TimeWidth-1:0] delay_ms;
	} upd_cmd_t;

	// Update result
	typedef struct packed {
		logic   we;
		logic   fired;
		entry_t entry;
	} upd_res_t;

endpackage

`default_nettype wire

>>> rtl/core/ketrq_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module ketrq_ram #(
	parameter int WIDTH = 35,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write one entry, read one entry with registered data
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/ketrq_update.sv
`timescale 1ns / 1ps
`default_nettype none

module ketrq_update (
	input  wire ketrq_pkg::upd_cmd_t             cmd,
	input  wire ketrq_pkg::entry_t               cur,
	input  wire logic [ketrq_pkg::TimeWidth-1:0] sampled_time,
	output ketrq_pkg::upd_res_t                  res
);

	logic [ketrq_pkg::TimeWidth-1:0] elapsed;
	logic                            press_fire;

	assign elapsed = sampled_time - cur.last_fire_time;

	// Rising-edge detect shared by press-once and toggle
	assign press_fire = cmd.down && !cur.down_mark;

	// Modify the key record for this query
	always_comb begin
		res.we    = 1'b0;
		res.fired = 1'b0;
		res.entry = cur;
		if (cmd.key_ok) begin
			unique case (cmd.action)
				ketrq_pkg::ACT_HOLD: begin
					res.fired = cmd.down;
				end
				ketrq_pkg::ACT_REPEAT: begin
					if (cmd.down && (elapsed > cmd.delay_ms)) begin
						res.entry.last_fire_time = sampled_time;
						res.we                   = 1'b1;
						res.fired                = 1'b1;
					end
				end
				ketrq_pkg::ACT_PRESS: begin
					res.entry.down_mark = cmd.down;
					res.we              = 1'b1;
					res.fired           = press_fire;
				end
				ketrq_pkg::ACT_RELEASE: begin
					if (cmd.down) begin
						res.entry.up_mark = 1'b1;
						res.we            = 1'b1;
					end else if (cur.up_mark) begin
						res.entry.up_mark = 1'b0;
						res.we            = 1'b1;
						res.fired         = 1'b1;
					end
				end
				ketrq_pkg::ACT_TOGGLE: begin
					res.entry.down_mark   = cmd.down;
					res.entry.toggle_mark = cur.toggle_mark ^ press_fire;
					res.we                = 1'b1;
					res.fired             = cur.toggle_mark ^ press_fire;
				end
				default: begin
					res.we = 1'b0;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/key_edge_toggle_repeat_qualifier_unit.sv
// Key edge, toggle and auto-repeat qualifier.
// Input channel (in_valid/in_stall): action, key, pressed, delay_ms, time_ms.
// A transfer happens at a clock edge with in_valid high and in_stall low.
// Output channel (out_valid/out_stall): one fired bit for every input item,
// in order. Configuration: cfg_we writes cfg_wdata into the focus bit.
// An accepted item waits in the read stage and then moves to the output
// register. Throughput: one item per cycle while out_stall is low; the
// per-key record sits in one synchronous memory, read at acceptance and
// written back as the item leaves the read stage, with the last write
// forwarded so that back-to-back queries on one key see fresh data.
// Reset: focus is set, sampled time cleared, and a clearing pass writes zero
// to every key record, during which in_stall stays high.
// Stall: while out_stall holds a result, one more item may be accepted and
// waits in the read stage; after that in_stall rises until the result moves.
`timescale 1ns / 1ps
`default_nettype none

module key_edge_toggle_repeat_qualifier_unit #(
	parameter int KEY_COUNT = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  action,
	input  wire logic [7:0]  key,
	input  wire logic        pressed,
	input  wire logic [31:0] delay_ms,
	input  wire logic [31:0] time_ms,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             fired
);

	localparam int AW = $clog2(KEY_COUNT);
	localparam int XW = (AW > 8) ? AW : 8;
	localparam int TW = ketrq_pkg::TimeWidth;

	logic                 focus_q;
	logic [TW-1:0]        sampled_time_q;
	logic                 clearing_q;
	logic [AW-1:0]        clr_cnt_q;

	logic                 valid_s1;
	logic [2:0]           action_s1;
	logic [AW-1:0]        addr_s1;
	logic                 key_ok_s1;
	logic                 down_s1;
	logic [TW-1:0]        delay_s1;
	logic [TW-1:0]        time_s1;

	logic                 lw_valid_q;
	logic [AW-1:0]        lw_addr_q;
	ketrq_pkg::entry_t    lw_data_q;

	logic                 out_valid_q;
	logic                 fired_q;

	logic [XW-1:0]        key_ext;
	logic [AW-1:0]        addr_in;
	logic                 accept;
	logic                 advance;
	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	logic [ketrq_pkg::EntryWidth-1:0] ram_wdata;
	logic [ketrq_pkg::EntryWidth-1:0] ram_rdata;
	ketrq_pkg::entry_t    cur_entry;
	ketrq_pkg::upd_cmd_t  cmd;
	ketrq_pkg::upd_res_t  res;

	assign key_ext = XW'(key);
	assign addr_in = key_ext[AW-1:0];

	// Handshake: s1 moves when the output register is free or taken
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = clearing_q || (valid_s1 && !advance);
	assign accept   = in_valid && !in_stall;

	// Focus register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focus_q <= 1'b1;
		end else if (cfg_we) begin
			focus_q <= cfg_wdata;
		end
	end

	// Clearing pass over the key memory after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clearing_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == AW'(KEY_COUNT - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// Read stage: capture the query while the memory read is in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1 <= action;
			addr_s1   <= addr_in;
			key_ok_s1 <= (32'(key) < KEY_COUNT);
			down_s1   <= focus_q && pressed;
			delay_s1  <= delay_ms;
			time_s1   <= time_ms;
		end
	end

	ketrq_ram #(
		.WIDTH(ketrq_pkg::EntryWidth),
		.DEPTH(KEY_COUNT)
	) u_key_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (accept),
		.raddr(addr_in),
		.rdata(ram_rdata)
	);

	// Forward the last write when it hits the same key
	assign cur_entry = (lw_valid_q && (lw_addr_q == addr_s1))
		? lw_data_q : ketrq_pkg::entry_t'(ram_rdata);

	assign cmd.action   = action_s1;
	assign cmd.key_ok   = key_ok_s1;
	assign cmd.down     = down_s1;
	assign cmd.delay_ms = delay_s1;

	ketrq_update u_update (
		.cmd         (cmd),
		.cur         (cur_entry),
		.sampled_time(sampled_time_q),
		.res         (res)
	);

	// Write port: zeros during the clearing pass, else the write-back
	always_comb begin
		if (clearing_q) begin
			ram_we    = 1'b1;
			ram_waddr = clr_cnt_q;
			ram_wdata = '0;
		end else begin
			ram_we    = advance && res.we;
			ram_waddr = addr_s1;
			ram_wdata = res.entry;
		end
	end

	// Track the last write-back for forwarding
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lw_valid_q <= 1'b0;
		end else if (!clearing_q && advance && res.we) begin
			lw_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!clearing_q && advance && res.we) begin
			lw_addr_q <= addr_s1;
			lw_data_q <= res.entry;
		end
	end

	// Sample time on a tick transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sampled_time_q <= '0;
		end else if (advance && (action_s1 == ketrq_pkg::ACT_TICK)) begin
			sampled_time_q <= time_s1;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			fired_q <= res.fired;
		end
	end

	assign out_valid = out_valid_q;
	assign fired     = fired_q;

endmodule

`default_nettype wire
